// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Wraps labeled assertions so that synthesis sees an empty body.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== src/frem_pkg.sv =====
// ----------------------------------------------------------------------------
// frem_pkg - shared types and constants of the floating remainder block
// Sequencer states and significand widths.
// ----------------------------------------------------------------------------
package frem_pkg;
	localparam int MantW = 53;  // significand with implicit bit
	localparam int ExpW  = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_REDUCE,
		ST_NORM,
		ST_DONE
	} frem_state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} frem_ctl_t;
endpackage

// ===== src/frem_core.sv =====
// ----------------------------------------------------------------------------
// frem_core - iterative shift-subtract remainder datapath
// Reduces one significand by another one bit per cycle, then normalizes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module frem_core import frem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frem_ctl_t   ctl,
	input  logic [63:0] a_bits,
	input  logic [63:0] b_bits,
	input  logic        sp,
	output logic        done,
	output logic [63:0] res,
	output logic        null_out
);
	frem_state_t state_q, state_d;
	logic [MantW:0]  r_q;
	logic [MantW-1:0] mb_q;
	logic [MantW-1:0] q_q;      // dividend significand bits still to shift in
	logic [11:0]     cnt_q;     // remaining shift-subtract steps
	logic [11:0]     e_q;
	logic [63:0]     res_q;
	logic            sa_q, sp_q, null_q;

	// decode operands in the selected precision
	logic [63:0] a, b, mag_a, mag_b, one, qnan, sgn, fmask, imp;
	logic [11:0] ea, eb, emax;
	logic        nul, spec;
	logic [63:0] spec_res, ma, mbv;
	logic [11:0] ea1, eb1;
	always_comb begin
		if (sp) begin
			a = {32'd0, a_bits[31:0]};
			b = {32'd0, b_bits[31:0]};
			mag_a = {33'd0, a[30:0]};
			mag_b = {33'd0, b[30:0]};
			one = 64'h3F80_0000;
			qnan = 64'h7FC0_0000;
			sgn = {32'd0, a[31], 31'd0};
			fmask = 64'h7F_FFFF;
			imp = 64'h80_0000;
			emax = 12'd255;
			nul = (mag_b == 64'd0);
			if (nul) mag_b = one;
			ea = {4'd0, mag_a[30:23]};
			eb = {4'd0, mag_b[30:23]};
		end else begin
			a = a_bits;
			b = b_bits;
			mag_a = {1'b0, a[62:0]};
			mag_b = {1'b0, b[62:0]};
			one = 64'h3FF0_0000_0000_0000;
			qnan = 64'h7FF8_0000_0000_0000;
			sgn = {a[63], 63'd0};
			fmask = 64'h000F_FFFF_FFFF_FFFF;
			imp = 64'h0010_0000_0000_0000;
			emax = 12'd2047;
			nul = (mag_b == 64'd0);
			if (nul) mag_b = one;
			ea = {1'b0, mag_a[62:52]};
			eb = {1'b0, mag_b[62:52]};
		end
		spec = 1'b1;
		if (ea == emax) spec_res = qnan;
		else if (eb == emax && (mag_b & fmask) != 64'd0) spec_res = qnan;
		else if (eb == emax) spec_res = a;
		else if (mag_a < mag_b) spec_res = a;
		else if (mag_a == mag_b) spec_res = sgn;
		else begin
			spec = 1'b0;
			spec_res = sgn;
		end
		ma = (ea != 12'd0) ? ((mag_a & fmask) | imp) : (mag_a & fmask);
		mbv = (eb != 12'd0) ? ((mag_b & fmask) | imp) : (mag_b & fmask);
		ea1 = (ea == 12'd0) ? 12'd1 : ea;
		eb1 = (eb == 12'd0) ? 12'd1 : eb;
	end

	// one shared subtract-compare step; dividend bits enter first, then zeros
	logic [MantW:0] sh, diff;
	logic           ge;
	always_comb begin
		sh = {r_q[MantW-1:0], q_q[MantW-1]};
		ge = (sh >= {1'b0, mb_q});
		diff = ge ? (sh - {1'b0, mb_q}) : sh;
	end

	logic [MantW:0] imp_w;
	assign imp_w = sp_q ? (54'd1 << 23) : (54'd1 << 52);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (ctl.start) state_d = spec ? ST_DONE : ST_REDUCE;
			ST_REDUCE: if (cnt_q == 12'd0) state_d = ST_NORM;
			ST_NORM: begin
				if (r_q == '0 || r_q >= imp_w || e_q <= 12'd1) state_d = ST_DONE;
			end
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (ctl.start) begin
				// long division: shift in all dividend bits, then one step per exponent
				r_q <= '0;
				q_q <= ma[MantW-1:0];
				mb_q <= mbv[MantW-1:0];
				cnt_q <= ea1 - eb1 + 12'(MantW);
				e_q <= eb1;
				sa_q <= sp ? a[31] : a[63];
				sp_q <= sp;
				null_q <= nul;
				res_q <= spec_res;
			end
			ST_REDUCE: if (cnt_q != 12'd0) begin
				r_q <= diff;
				q_q <= {q_q[MantW-2:0], 1'b0};
				cnt_q <= cnt_q - 12'd1;
			end
			ST_NORM: begin
				if (r_q == '0) res_q <= sp_q ? {32'd0, sa_q, 31'd0} : {sa_q, 63'd0};
				else if (r_q >= imp_w) begin
					res_q <= sp_q ? {32'd0, sa_q, e_q[7:0], r_q[22:0]}
						: {sa_q, e_q[10:0], r_q[51:0]};
				end else if (e_q <= 12'd1) begin
					res_q <= sp_q ? {32'd0, sa_q, 8'd0, r_q[22:0]}
						: {sa_q, 11'd0, r_q[51:0]};
				end else begin
					r_q <= {r_q[MantW-1:0], 1'b0};
					e_q <= e_q - 12'd1;
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == ST_DONE);
	assign res = res_q;
	assign null_out = null_q;

	`ASSERT_IMPL(a_rem_below, clk, arst_n, (state_q == ST_REDUCE) |-> (r_q < {1'b0, mb_q}))
	`ASSERT_IMPL(a_start_idle, clk, arst_n, ctl.start |-> (state_q == ST_IDLE))
	`ASSERT_IMPL(a_done_one, clk, arst_n, done |=> (state_q == ST_IDLE))
endmodule

// ===== src/float_remainder_with_null.sv =====
// ----------------------------------------------------------------------------
// float_remainder_with_null - exact IEEE fmod with zero-divisor flag
// Stream wrapper around the iterative remainder core.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operand pair per transaction; m_* returns one result.
//   s_tdata = {divisor_bits, dividend_bits}, s_tuser = single_precision,
//   s_tlast = last_in. m_tdata = remainder_bits, m_tuser = null_flag,
//   m_tlast = last_out.
//   Special cases skip the loop; any other item runs through the one-bit-per-
//   cycle shift-subtract loop, which first shifts in all 53 dividend bits,
//   then takes one step per unit of exponent difference, followed by the
//   normalizing shifts. Only one item is in flight at a time.
//   s_tready is high only while the core is idle and the output register
//   is empty; a new item can enter only in the cycle after the waiting
//   result is taken. A stalled receiver holds m_tvalid and data.
//   Reset clears the sequencer and the output valid.
`include "assert_macros.svh"
module float_remainder_with_null import frem_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // divisor_bits, dividend_bits
	input  logic         s_tuser,  // single_precision
	input  logic         s_tlast,  // last_in
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // remainder_bits
	output logic         m_tuser,  // null_flag
	output logic         m_tlast   // last_out
);
	frem_ctl_t   ctl;
	logic        busy_q, vld_q, last_q, done;
	logic [63:0] res;
	logic        nul;

	assign s_tready = !busy_q && !vld_q;
	assign ctl.start = s_tvalid && s_tready;
	assign ctl.busy = busy_q;

	frem_core u_core (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.a_bits(s_tdata[63:0]), .b_bits(s_tdata[127:64]), .sp(s_tuser),
		.done(done), .res(res), .null_out(nul)
	);

	// track the item in flight and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			if (ctl.start) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) vld_q <= 1'b1;
			else if (m_tready) vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) last_q <= s_tlast;
		if (done) begin
			m_tdata <= res;
			m_tuser <= nul;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tlast = last_q;

	`ASSERT_IMPL(a_done_busy, clk, arst_n, done |-> busy_q)
	`ASSERT_IMPL(a_no_overlap, clk, arst_n, done |-> !vld_q)
	`ASSERT_IMPL(a_ready_excl, clk, arst_n, s_tready |-> !m_tvalid)
endmodule
